[rtl/octave_value_noise_2d_unit_assert.svh]
// Assertion macros used by the noise unit sequencer.
`ifndef OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH

// Same-cycle implication.
`define OVN2D_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ovn2d assertion failed");

// Next-cycle implication.
`define OVN2D_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ovn2d assertion failed");

`endif

[rtl/ovn2d_pkg.sv]
// Types and constants of the octave value noise unit.
package ovn2d_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int OCT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_GAIN  = 2'd1;

  localparam logic [3:0]  OCTAVE_COUNT_RESET = 4'd8;
  localparam logic [13:0] OCTAVE_GAIN_RESET  = 14'd2048;
  localparam logic [31:0] SCALE_ONE          = 32'd4096;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_HMUL,
    ST_VMUL,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic             wr;
    logic             rd;
    logic [1:0]       corner;
    logic [OCT_W-1:0] oct;
    logic             hmul;
    logic             vmul;
    logic             accum;
    logic             div_init;
    logic             div_step;
    logic             out_load;
  } cmd_t;

endpackage

[rtl/ovn2d_if.sv]
// Handshake channel interfaces of the noise unit.
interface ovn2d_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] seed_value;
  modport source (output valid, kind, pos_x, pos_y, seed_value, input ready);
  modport sink (input valid, kind, pos_x, pos_y, seed_value, output ready);
endinterface

interface ovn2d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  modport source (output valid, noise_value, out_x, out_y, input ready);
  modport sink (input valid, noise_value, out_x, out_y, output ready);
endinterface

interface ovn2d_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/octave_value_noise_2d_unit.sv]
// Top level: a query makes one pass per octave, then runs the divider, and its result
// loads into the output register; each octave reads its four corner seeds through the
// single seed memory read port and then uses the blend multipliers and accumulator.
// Input reopens the cycle after the result loads, later while a waiting result is not taken.
// A load item is written to seed memory as it is accepted, and input stays open.
// Reset clears the sequencer and output valid, restores config defaults; seed memory is not cleared.
module octave_value_noise_2d_unit
  import ovn2d_pkg::*;
#(
  parameter int GRID_LOG2 = 8,
  parameter int SEED_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  ovn2d_in_if.sink   in_ch,
  ovn2d_out_if.source out_ch,
  ovn2d_cfg_if.sink  cfg_ch
);

  logic [3:0]  oc_r;
  logic [13:0] gain_r;
  cmd_t        cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r   <= OCTAVE_COUNT_RESET;
      gain_r <= OCTAVE_GAIN_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_OCTAVE_COUNT) oc_r <= cfg_ch.data[3:0];
      else if (cfg_ch.index == REG_OCTAVE_GAIN) gain_r <= cfg_ch.data;
    end
  end

  ovn2d_ctrl #(
    .GRID_LOG2(GRID_LOG2),
    .SEED_BITS(SEED_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_kind     (in_ch.kind),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .octave_count(oc_r),
    .cmd         (cmd)
  );

  ovn2d_datapath #(
    .GRID_LOG2(GRID_LOG2),
    .SEED_BITS(SEED_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .pos_x      (in_ch.pos_x),
    .pos_y      (in_ch.pos_y),
    .seed_value (in_ch.seed_value),
    .gain       (gain_r),
    .noise_value(out_ch.noise_value),
    .out_x      (out_ch.out_x),
    .out_y      (out_ch.out_y)
  );

endmodule

[rtl/ovn2d_datapath.sv]
// Seed memory, bilinear blend, octave accumulation and divider.
module ovn2d_datapath
  import ovn2d_pkg::*;
#(
  parameter int GRID_LOG2 = 8,
  parameter int SEED_BITS = 16
) (
  input  logic        clk,
  input  cmd_t        cmd,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [15:0] seed_value,
  input  logic [13:0] gain,
  output logic [15:0] noise_value,
  output logic [7:0]  out_x,
  output logic [7:0]  out_y
);

  localparam int G    = GRID_LOG2;
  localparam int SB   = SEED_BITS;
  localparam int AW   = 2 * G;
  localparam int TW   = SB + G + 1;
  localparam int PW   = SB + 2 * G + 1;
  localparam int WSW  = 36;
  localparam int ACCW = SB + WSW;
  localparam int DVW  = ACCW + SB;
  localparam logic [G:0] GRID_W = (G + 1)'(1) << G;

  logic [SB-1:0] mem [2**AW];

  logic [G-1:0]    x_r, y_r;
  logic [7:0]      px_r, py_r;
  logic [SB-1:0]   s_r [4];
  logic [TW-1:0]   top_r, bot_r;
  logic [SB-1:0]   p_r;
  logic [ACCW-1:0] acc_r;
  logic [WSW-1:0]  wsum_r;
  logic [31:0]     scale_r;
  logic [DVW-1:0]  rem_r, dvs_r;
  logic [SB-1:0]   q_r;
  logic [15:0]     noise_r;
  logic [7:0]      ox_r, oy_r;

  logic [G-1:0]     x_in, y_in, lowmask, x0, x1, y0, y1, bx, by, row, col;
  logic [G:0]       wx0, wy0;
  logic [AW-1:0]    waddr, raddr;
  logic [SB-1:0]    seed_al;
  logic [TW-1:0]    top_nxt, bot_nxt;
  logic [PW-1:0]    vsum;
  logic [ACCW-1:0]  prod;
  logic [45:0]      ns;
  logic [31:0]      scale_nxt;
  logic             ge;
  logic [SB+15:0]   q_al;
  logic [SB+15:0]   sv_al;

  always_comb begin
    x_in    = G'({{G{1'b0}}, pos_x});
    y_in    = G'({{G{1'b0}}, pos_y});
    waddr   = {y_in, x_in};
    sv_al   = {seed_value, {SB{1'b0}}} >> 16;
    seed_al = sv_al[SB-1:0];

    lowmask = {G{1'b1}} >> cmd.oct;
    x0      = x_r & ~lowmask;
    y0      = y_r & ~lowmask;
    x1      = x0 + G'(lowmask + G'(1));
    y1      = y0 + G'(lowmask + G'(1));
    bx      = G'((x_r & lowmask) << cmd.oct);
    by      = G'((y_r & lowmask) << cmd.oct);
    wx0     = GRID_W - {1'b0, bx};
    wy0     = GRID_W - {1'b0, by};

    unique case (cmd.corner)
      2'd0:    begin row = y0; col = x0; end
      2'd1:    begin row = y0; col = x1; end
      2'd2:    begin row = y1; col = x0; end
      default: begin row = y1; col = x1; end
    endcase
    raddr = {row, col};

    top_nxt = TW'(s_r[0]) * TW'(wx0) + TW'(s_r[1]) * TW'(bx);
    bot_nxt = TW'(s_r[2]) * TW'(wx0) + TW'(s_r[3]) * TW'(bx);
    vsum    = PW'(top_r) * PW'(wy0) + PW'(bot_r) * PW'(by);

    prod = ACCW'(p_r) * ACCW'(scale_r);
    ns   = 46'(scale_r) * 46'(gain);
    // saturate the decayed scale at all ones
    scale_nxt = (ns[45:44] != 2'b00) ? 32'hFFFF_FFFF : ns[43:12];

    ge   = rem_r >= dvs_r;
    q_al = {q_r, 16'b0} >> SB;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[waddr] <= seed_al;
    if (cmd.rd) s_r[cmd.corner] <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r     <= x_in;
      y_r     <= y_in;
      px_r    <= pos_x;
      py_r    <= pos_y;
      acc_r   <= '0;
      wsum_r  <= '0;
      scale_r <= SCALE_ONE;
    end
    if (cmd.hmul) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
    if (cmd.vmul) p_r <= vsum[AW +: SB];
    if (cmd.accum) begin
      acc_r   <= acc_r + prod;
      wsum_r  <= wsum_r + WSW'(scale_r);
      scale_r <= scale_nxt;
    end
    if (cmd.div_init) begin
      rem_r <= DVW'(acc_r);
      dvs_r <= DVW'(wsum_r) << (SB - 1);
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dvs_r;
      dvs_r <= dvs_r >> 1;
      q_r   <= {q_r[SB-2:0], ge};
    end
    if (cmd.out_load) begin
      noise_r <= q_al[15:0];
      ox_r    <= px_r;
      oy_r    <= py_r;
    end
  end

  assign noise_value = noise_r;
  assign out_x       = ox_r;
  assign out_y       = oy_r;

endmodule

[rtl/ovn2d_ctrl.sv]
// Sequencer for loads, octave passes, division and result handoff.
`include "octave_value_noise_2d_unit_assert.svh"
module ovn2d_ctrl
  import ovn2d_pkg::*;
#(
  parameter int GRID_LOG2 = 8,
  parameter int SEED_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] octave_count,
  output cmd_t       cmd
);

  localparam int DCW = $clog2(SEED_BITS);
  localparam logic [OCT_W-1:0] MAX_N    = OCT_W'(GRID_LOG2 + 1);
  localparam logic [DCW-1:0]   DIV_LAST = DCW'(SEED_BITS - 1);

  state_t           state_r, state_nxt;
  logic [1:0]       corner_r, corner_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt, nlast_r, nlast_nxt;
  logic [DCW-1:0]   dcnt_r, dcnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      corner_r    <= '0;
      oct_r       <= '0;
      nlast_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      corner_r    <= corner_nxt;
      oct_r       <= oct_nxt;
      nlast_r     <= nlast_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    corner_nxt    = corner_r;
    oct_nxt       = oct_r;
    nlast_nxt     = nlast_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    in_ready      = (state_r == ST_IDLE);
    accept        = in_valid && in_ready;
    cmd           = '0;
    cmd.corner    = corner_r;
    cmd.oct       = oct_r;

    // drop the result once taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        cmd.wr = accept && !in_kind;
        if (accept && in_kind) begin
          cmd.start  = 1'b1;
          corner_nxt = '0;
          oct_nxt    = '0;
          if (octave_count == '0) nlast_nxt = '0;
          else if (octave_count > MAX_N) nlast_nxt = MAX_N - OCT_W'(1);
          else nlast_nxt = octave_count - OCT_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        corner_nxt = corner_r + 2'd1;
        if (corner_r == CORNER_LAST) state_nxt = ST_HMUL;
      end
      ST_HMUL: begin
        cmd.hmul  = 1'b1;
        state_nxt = ST_VMUL;
      end
      ST_VMUL: begin
        cmd.vmul  = 1'b1;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        if (oct_r == nlast_r) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          oct_nxt   = oct_r + OCT_W'(1);
          state_nxt = ST_READ;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCW'(1);
        if (dcnt_r == DIV_LAST) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `OVN2D_ASSERT_IMPL(a_one_mem_op, clk, rst_n, cmd.rd, !cmd.wr)
  `OVN2D_ASSERT_IMPL(a_oct_bound, clk, rst_n, state_r != ST_IDLE, oct_r <= nlast_r)
  `OVN2D_ASSERT_NEXT(a_query_reads, clk, rst_n, accept && in_kind, state_r == ST_READ)
  `OVN2D_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.out_load, out_valid_r)

endmodule
